@@ design/imu_pkg.sv @@
// Shared types, constants and a helper function for the Ising Metropolis update core.
package imu_pkg;

   // Fixed field widths of the item and register formats.
   localparam int COORD_W       = 8;
   localparam int SITE_W        = 6;
   localparam int SIZE_W        = 7;
   localparam int SWEEP_W       = 13;
   localparam int SWEEP_COUNT_W = 32;
   localparam int RAND_W        = 16;
   localparam int THR_W         = 17;
   localparam int THR_WORD_W    = 51;
   localparam int THR_WORDS     = 5;
   localparam int ENTRY_W       = 4;
   localparam int CSR_INDEX_W   = 3;

   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 7'd64;
   localparam logic [SWEEP_W-1:0] SWEEP_RESET = 13'd4096;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SIZE_X       = 3'd0,
      CSR_SIZE_Y       = 3'd1,
      CSR_SWEEP_LENGTH = 3'd2,
      CSR_THR_WORD0    = 3'd3,
      CSR_THR_WORD1    = 3'd4,
      CSR_THR_WORD2    = 3'd5,
      CSR_THR_WORD3    = 3'd6,
      CSR_THR_WORD4    = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_RD_PREV,
      BK_RD_CUR,
      BK_RD_NEXT,
      BK_EVAL,
      BK_WRITE
   } back_state_type;

   typedef logic [THR_WORDS-1:0][THR_WORD_W-1:0] thr_words_type;

   typedef struct packed {
      logic [SIZE_W-1:0]  size_x;
      logic [SIZE_W-1:0]  size_y;
      logic [SWEEP_W-1:0] sweep_length;
      thr_words_type      thr_words;
   } cfg_type;

   typedef struct packed {
      logic              req_type;
      logic [SITE_W-1:0] site_x;
      logic [SITE_W-1:0] site_y;
      logic [RAND_W-1:0] random_fraction;
      logic              spin_in;
   } req_item_type;

   typedef struct packed {
      logic                     accepted;
      logic                     spin_after;
      logic                     sweep_done;
      logic [SWEEP_W-1:0]       sweep_accepts;
      logic [SWEEP_COUNT_W-1:0] sweep_count;
   } rsp_item_type;

   // Decoded command handed from the front end to the back end.
   typedef struct packed {
      logic               is_write;
      logic               spin_in;
      logic [RAND_W-1:0]  rnd;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] xp;
      logic [COORD_W-1:0] xn;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] yp;
      logic [COORD_W-1:0] yn;
   } cmd_type;

   // Picks the acceptance threshold for entry = energy index * 2 + spin.
   function automatic logic [THR_W-1:0] thr_select(input thr_words_type words,
                                                    input logic [ENTRY_W-1:0] entry);
      logic [THR_W-1:0] thr;
      case (entry)
         4'd0:    thr = words[0][16:0];
         4'd1:    thr = words[0][33:17];
         4'd2:    thr = words[0][50:34];
         4'd3:    thr = words[1][16:0];
         4'd4:    thr = words[1][33:17];
         4'd5:    thr = words[1][50:34];
         4'd6:    thr = words[2][16:0];
         4'd7:    thr = words[2][33:17];
         4'd8:    thr = words[2][50:34];
         4'd9:    thr = words[3][16:0];
         4'd10:   thr = words[3][33:17];
         4'd11:   thr = words[3][50:34];
         4'd12:   thr = words[4][16:0];
         4'd13:   thr = words[4][33:17];
         default: thr = '0;
      endcase
      return thr;
   endfunction

endpackage

@@ design/imu_fifo.sv @@
// Small first-in first-out queue used between the core's stages.
module imu_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

@@ design/imu_front.sv @@
// Front end: clamps the site, works out the wrapped neighbour coordinates and masks the random value.
module imu_front #(
   parameter int MAX_X     = 64,
   parameter int MAX_Y     = 64,
   parameter int RAND_BITS = 16
) (
   input  imu_pkg::cfg_type      cfg,
   input  imu_pkg::req_item_type req,
   output imu_pkg::cmd_type      cmd
);

   localparam int XW  = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YW  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int SXW = XW + 1;
   localparam int SYW = YW + 1;
   localparam logic [imu_pkg::RAND_W-1:0] RND_MASK =
      (RAND_BITS >= imu_pkg::RAND_W) ? '1
                                     : imu_pkg::RAND_W'((32'd1 << RAND_BITS) - 32'd1);

   logic [SXW-1:0] eff_sx, x_inc;
   logic [SYW-1:0] eff_sy, y_inc;
   logic [XW-1:0]  x_c, x_p, x_n;
   logic [YW-1:0]  y_c, y_p, y_n;

   always_comb begin
      // A size of zero acts as one; a size beyond the lattice acts as the lattice size.
      if (cfg.size_x == '0) begin
         eff_sx = SXW'(1);
      end else if (32'(cfg.size_x) > 32'(MAX_X)) begin
         eff_sx = SXW'(MAX_X);
      end else begin
         eff_sx = SXW'(cfg.size_x);
      end
      if (cfg.size_y == '0) begin
         eff_sy = SYW'(1);
      end else if (32'(cfg.size_y) > 32'(MAX_Y)) begin
         eff_sy = SYW'(MAX_Y);
      end else begin
         eff_sy = SYW'(cfg.size_y);
      end

      x_c = (32'(req.site_x) >= 32'(eff_sx)) ? XW'(eff_sx - SXW'(1)) : XW'(req.site_x);
      y_c = (32'(req.site_y) >= 32'(eff_sy)) ? YW'(eff_sy - SYW'(1)) : YW'(req.site_y);

      x_p   = (x_c == '0) ? XW'(eff_sx - SXW'(1)) : x_c - XW'(1);
      y_p   = (y_c == '0) ? YW'(eff_sy - SYW'(1)) : y_c - YW'(1);
      x_inc = SXW'(x_c) + SXW'(1);
      y_inc = SYW'(y_c) + SYW'(1);
      x_n   = (x_inc >= eff_sx) ? '0 : XW'(x_inc);
      y_n   = (y_inc >= eff_sy) ? '0 : YW'(y_inc);

      cmd.is_write = req.req_type;
      cmd.spin_in  = req.spin_in;
      cmd.rnd      = req.random_fraction & RND_MASK;
      cmd.x        = imu_pkg::COORD_W'(x_c);
      cmd.xp       = imu_pkg::COORD_W'(x_p);
      cmd.xn       = imu_pkg::COORD_W'(x_n);
      cmd.y        = imu_pkg::COORD_W'(y_c);
      cmd.yp       = imu_pkg::COORD_W'(y_p);
      cmd.yn       = imu_pkg::COORD_W'(y_n);
   end

endmodule

@@ design/imu_back.sv @@
// Back end: lattice memory, neighbour reads, flip decision and sweep counters.
module imu_back #(
   parameter int MAX_X = 64,
   parameter int MAX_Y = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  imu_pkg::cfg_type      cfg,
   input  logic                  cmd_empty,
   input  imu_pkg::cmd_type      cmd_data,
   output logic                  cmd_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output imu_pkg::rsp_item_type rsp_data,
   output logic                  clearing
);

   localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;

   imu_pkg::back_state_type state_ff, state_in;
   imu_pkg::cmd_type        cmd_ff;

   logic [MAX_Y-1:0] lattice_mem [MAX_X];
   logic [MAX_Y-1:0] rd_data_ff, row_prev_ff, row_cur_ff;
   logic [MAX_Y-1:0] wr_data, row_flip, row_wr;
   logic [XW-1:0]    rd_addr, wr_addr;
   logic             wr_en;
   logic [XW-1:0]    clr_row_ff, clr_row_in;

   logic [imu_pkg::SWEEP_W-1:0]       attempt_ff, attempt_in, attempt_inc;
   logic [imu_pkg::SWEEP_W-1:0]       accept_ff, accept_in, accept_inc;
   logic [imu_pkg::SWEEP_COUNT_W-1:0] sweep_ff, sweep_in;
   logic                              ctr_update;

   logic [YW-1:0]                 y_c, y_p, y_n;
   logic                          s_cur, flip, spin_new, done;
   logic [2:0]                    eq;
   logic [imu_pkg::ENTRY_W-1:0]   entry;
   logic [imu_pkg::THR_W-1:0]     thr;

   assign clearing = (state_ff == imu_pkg::BK_CLEAR);

   // Flip decision, row to write, sweep counters and result, from the three rows held after the read sequence.
   always_comb begin
      y_c   = cmd_ff.y[YW-1:0];
      y_p   = cmd_ff.yp[YW-1:0];
      y_n   = cmd_ff.yn[YW-1:0];
      s_cur = row_cur_ff[y_c];
      eq = 3'(row_prev_ff[y_c] == s_cur) + 3'(rd_data_ff[y_c] == s_cur)
         + 3'(row_cur_ff[y_p] == s_cur)  + 3'(row_cur_ff[y_n] == s_cur)
         + 3'(row_prev_ff[y_n] == s_cur) + 3'(rd_data_ff[y_p] == s_cur);
      entry    = {eq, s_cur};
      thr      = imu_pkg::thr_select(cfg.thr_words, entry);
      flip     = ({1'b0, cmd_ff.rnd} < thr);
      spin_new = flip ? ~s_cur : s_cur;

      row_flip      = row_cur_ff;
      row_flip[y_c] = spin_new;
      row_wr        = rd_data_ff;
      row_wr[y_c]   = cmd_ff.spin_in;

      attempt_inc = attempt_ff + imu_pkg::SWEEP_W'(1);
      accept_inc  = accept_ff + imu_pkg::SWEEP_W'(flip);
      done        = (attempt_inc >= cfg.sweep_length) || (attempt_inc == '0);

      attempt_in = done ? '0 : attempt_inc;
      accept_in  = done ? '0 : accept_inc;
      sweep_in   = done ? sweep_ff + imu_pkg::SWEEP_COUNT_W'(1) : sweep_ff;

      if (state_ff == imu_pkg::BK_WRITE) begin
         rsp_data.accepted      = 1'b0;
         rsp_data.spin_after    = cmd_ff.spin_in;
         rsp_data.sweep_done    = 1'b0;
         rsp_data.sweep_accepts = '0;
         rsp_data.sweep_count   = sweep_ff;
      end else begin
         rsp_data.accepted      = flip;
         rsp_data.spin_after    = spin_new;
         rsp_data.sweep_done    = done;
         rsp_data.sweep_accepts = done ? accept_inc : '0;
         rsp_data.sweep_count   = sweep_in;
      end
   end

   // Sequencer: clear pass, then per attempt the previous, current and next rows, per write the current row alone.
   always_comb begin
      state_in   = state_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      ctr_update = 1'b0;
      rd_addr    = cmd_ff.x[XW-1:0];
      wr_en      = 1'b0;
      wr_addr    = cmd_ff.x[XW-1:0];
      wr_data    = row_flip;
      clr_row_in = clr_row_ff;
      case (state_ff)
         imu_pkg::BK_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_row_ff;
            wr_data    = '1;
            clr_row_in = clr_row_ff + XW'(1);
            if (clr_row_ff == XW'(MAX_X - 1)) begin
               state_in = imu_pkg::BK_IDLE;
            end
         end
         imu_pkg::BK_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop  = 1'b1;
               state_in = cmd_data.is_write ? imu_pkg::BK_RD_CUR : imu_pkg::BK_RD_PREV;
            end
         end
         imu_pkg::BK_RD_PREV: begin
            rd_addr  = cmd_ff.xp[XW-1:0];
            state_in = imu_pkg::BK_RD_CUR;
         end
         imu_pkg::BK_RD_CUR: begin
            rd_addr  = cmd_ff.x[XW-1:0];
            state_in = cmd_ff.is_write ? imu_pkg::BK_WRITE : imu_pkg::BK_RD_NEXT;
         end
         imu_pkg::BK_RD_NEXT: begin
            rd_addr  = cmd_ff.xn[XW-1:0];
            state_in = imu_pkg::BK_EVAL;
         end
         imu_pkg::BK_EVAL: begin
            wr_en      = 1'b1;
            wr_data    = row_flip;
            rsp_push   = 1'b1;
            ctr_update = 1'b1;
            state_in   = imu_pkg::BK_IDLE;
         end
         imu_pkg::BK_WRITE: begin
            wr_en    = 1'b1;
            wr_data  = row_wr;
            rsp_push = 1'b1;
            state_in = imu_pkg::BK_IDLE;
         end
         default: begin
            state_in = imu_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= imu_pkg::BK_CLEAR;
         clr_row_ff <= '0;
         attempt_ff <= '0;
         accept_ff  <= '0;
         sweep_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         clr_row_ff <= clr_row_in;
         if (ctr_update) begin
            attempt_ff <= attempt_in;
            accept_ff  <= accept_in;
            sweep_ff   <= sweep_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
      end
      if (state_ff == imu_pkg::BK_RD_CUR) begin
         row_prev_ff <= rd_data_ff;
      end
      if (state_ff == imu_pkg::BK_RD_NEXT) begin
         row_cur_ff <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= lattice_mem[rd_addr];
      if (wr_en) begin
         lattice_mem[wr_addr] <= wr_data;
      end
   end

endmodule

@@ design/ising_metropolis_update_core.sv @@
// Top level of the Metropolis spin-flip core for a periodic triangular Ising lattice.
//
// Items arrive through a queue-like port: an item transfers on a clock edge with req_push
// high and req_full low. Attempts flip the spin at a site when the random fraction lies
// below the threshold chosen by the count of like neighbours and the current spin; write
// items load a spin. Every item gives one result, read from a queue-like port: the oldest
// result sits on rsp_payload while rsp_empty is low and transfers when rsp_pop is high.
// Registers are written over the csr_ port, which is always ready; write them only while
// the core is idle.
// The back end takes an item from the command queue only once the last one is written
// back and its result is in the result queue. Its pace is set by the single read port of
// the lattice memory, which holds one row per first coordinate and is read for the
// previous, current and next rows in turn for an attempt, or for the current row alone
// for a write, before the updated row is written back.
// A two-entry command queue lets the next item transfer while one is being worked on.
// After reset the lattice is set to all spins up by a pass over its MAX_X rows, one row a
// cycle, during which req_full stays high; counters and registers return to their reset
// values. When the receiver stops popping, the two-entry result queue fills, the back
// end holds off, then the command queue fills and req_full rises; nothing is lost.
module ising_metropolis_update_core #(
   parameter int MAX_X     = 64,
   parameter int MAX_Y     = 64,
   parameter int RAND_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  imu_pkg::req_item_type               req_payload,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output imu_pkg::rsp_item_type               rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [imu_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [imu_pkg::THR_WORD_W-1:0]      csr_wdata
);

   imu_pkg::cfg_type      cfg_ff, cfg_in;
   imu_pkg::cmd_type      front_cmd, back_cmd;
   imu_pkg::rsp_item_type back_rsp;
   logic                  cmd_full, cmd_empty, cmd_pop;
   logic                  rsp_full, rsp_push;
   logic                  clearing;

   // The register port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            imu_pkg::CSR_SIZE_X:       cfg_in.size_x       = csr_wdata[imu_pkg::SIZE_W-1:0];
            imu_pkg::CSR_SIZE_Y:       cfg_in.size_y       = csr_wdata[imu_pkg::SIZE_W-1:0];
            imu_pkg::CSR_SWEEP_LENGTH: cfg_in.sweep_length = csr_wdata[imu_pkg::SWEEP_W-1:0];
            imu_pkg::CSR_THR_WORD0:    cfg_in.thr_words[0] = csr_wdata;
            imu_pkg::CSR_THR_WORD1:    cfg_in.thr_words[1] = csr_wdata;
            imu_pkg::CSR_THR_WORD2:    cfg_in.thr_words[2] = csr_wdata;
            imu_pkg::CSR_THR_WORD3:    cfg_in.thr_words[3] = csr_wdata;
            imu_pkg::CSR_THR_WORD4:    cfg_in.thr_words[4] = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_x       <= imu_pkg::SIZE_RESET;
         cfg_ff.size_y       <= imu_pkg::SIZE_RESET;
         cfg_ff.sweep_length <= imu_pkg::SWEEP_RESET;
         cfg_ff.thr_words    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Items are held off while the lattice is being set after reset.
   assign req_full = cmd_full || clearing;

   imu_front #(
      .MAX_X     (MAX_X),
      .MAX_Y     (MAX_Y),
      .RAND_BITS (RAND_BITS)
   ) u_front (
      .cfg (cfg_ff),
      .req (req_payload),
      .cmd (front_cmd)
   );

   imu_fifo #(
      .WIDTH ($bits(imu_pkg::cmd_type)),
      .DEPTH (2)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push && !clearing),
      .wr_data (front_cmd),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (back_cmd),
      .empty   (cmd_empty)
   );

   imu_back #(
      .MAX_X (MAX_X),
      .MAX_Y (MAX_Y)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (cmd_empty),
      .cmd_data  (back_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_data  (back_rsp),
      .clearing  (clearing)
   );

   imu_fifo #(
      .WIDTH ($bits(imu_pkg::rsp_item_type)),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_payload),
      .empty   (rsp_empty)
   );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the triangular-lattice Metropolis spin-flip core.
module testbench;

   // Lattice extent as built, and the bounds of the run.
   localparam int GRID         = 64;
   localparam int ENTRIES      = 14;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int REPORT_LIMIT = 60;
   localparam int RANDOM_ITEMS = 330;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_push    = 1'b0;
   logic                            req_full;
   imu_pkg::req_item_type           req_payload = '0;
   logic                            rsp_empty;
   logic                            rsp_pop     = 1'b0;
   imu_pkg::rsp_item_type           rsp_payload;
   logic                            csr_valid   = 1'b0;
   logic                            csr_ready;
   logic [imu_pkg::CSR_INDEX_W-1:0] csr_index   = imu_pkg::CSR_SIZE_X;
   logic [imu_pkg::THR_WORD_W-1:0]  csr_wdata   = '0;

   ising_metropolis_update_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #6 clock = ~clock;

   // Our own copy of the core's state: the spin lattice, the register file and the sweep
   // bookkeeping. It is advanced once for every item at the edge on which that item transfers.
   logic                              spin_grid [GRID][GRID];
   logic [imu_pkg::SIZE_W-1:0]        extent_x;
   logic [imu_pkg::SIZE_W-1:0]        extent_y;
   logic [imu_pkg::SWEEP_W-1:0]       sweep_len;
   imu_pkg::thr_words_type            thr_bank;
   logic [imu_pkg::SWEEP_W-1:0]       attempts_in_sweep;
   logic [imu_pkg::SWEEP_W-1:0]       flips_in_sweep;
   logic [imu_pkg::SWEEP_COUNT_W-1:0] sweeps_total;

   // Results still owed by the core, oldest first.
   imu_pkg::rsp_item_type owed_results[$];

   int     send_idle_pct = 0;
   int     pop_idle_pct  = 0;
   int     errors        = 0;
   int     items_sent    = 0;
   int     results_seen  = 0;
   int     sweeps_seen   = 0;
   int     flips_seen    = 0;
   longint cycle_count   = 0;

   function automatic void reset_lattice_model();
      extent_x          = imu_pkg::SIZE_RESET;
      extent_y          = imu_pkg::SIZE_RESET;
      sweep_len         = imu_pkg::SWEEP_RESET;
      thr_bank          = '0;
      attempts_in_sweep = '0;
      flips_in_sweep    = '0;
      sweeps_total      = '0;
      for (int i = 0; i < GRID; i++) begin
         for (int j = 0; j < GRID; j++) begin
            spin_grid[i][j] = 1'b1;
         end
      end
   endfunction

   // A size of zero behaves as one, and anything above the built extent as the built extent.
   function automatic int used_extent(logic [imu_pkg::SIZE_W-1:0] s);
      if (int'(s) == 0) return 1;
      if (int'(s) > GRID) return GRID;
      return int'(s);
   endfunction

   // Works out the result of one item and moves the lattice and counters on by it.
   function automatic imu_pkg::rsp_item_type predict_spin_update(imu_pkg::req_item_type it);
      imu_pkg::rsp_item_type     r;
      int                        sx, sy, x, y, xp, xn, yp, yn, like, entry;
      logic                      s;
      logic [imu_pkg::THR_W-1:0] thr;
      sx = used_extent(extent_x);
      sy = used_extent(extent_y);
      x  = int'(it.site_x);
      y  = int'(it.site_y);
      if (x >= sx) x = sx - 1;
      if (y >= sy) y = sy - 1;
      r = '0;
      if (it.req_type) begin
         spin_grid[x][y] = it.spin_in;
      end else begin
         s  = spin_grid[x][y];
         xp = (x == 0) ? sx - 1 : x - 1;
         xn = (x + 1 >= sx) ? 0 : x + 1;
         yp = (y == 0) ? sy - 1 : y - 1;
         yn = (y + 1 >= sy) ? 0 : y + 1;
         // Six neighbours of the triangular lattice: the four axial ones and the two
         // anti-diagonals. On a lattice one site wide the x neighbours are the site itself.
         like = 0;
         like += int'(spin_grid[xp][y] == s);
         like += int'(spin_grid[xn][y] == s);
         like += int'(spin_grid[x][yp] == s);
         like += int'(spin_grid[x][yn] == s);
         like += int'(spin_grid[xp][yn] == s);
         like += int'(spin_grid[xn][yp] == s);
         entry = like * 2 + int'(s);
         thr   = thr_bank[entry / 3][imu_pkg::THR_W * (entry % 3) +: imu_pkg::THR_W];
         if ({1'b0, it.random_fraction} < thr) begin
            spin_grid[x][y] = ~s;
            r.accepted      = 1'b1;
         end
         flips_in_sweep    = flips_in_sweep + imu_pkg::SWEEP_W'(r.accepted);
         attempts_in_sweep = attempts_in_sweep + imu_pkg::SWEEP_W'(1);
         // A sweep closes once the count reaches the length, so a length cut below the
         // running count closes it on the next attempt, and a length of zero acts as one.
         if (attempts_in_sweep >= sweep_len || attempts_in_sweep == '0) begin
            r.sweep_done      = 1'b1;
            r.sweep_accepts   = flips_in_sweep;
            sweeps_total      = sweeps_total + imu_pkg::SWEEP_COUNT_W'(1);
            attempts_in_sweep = '0;
            flips_in_sweep    = '0;
         end
      end
      r.spin_after  = spin_grid[x][y];
      r.sweep_count = sweeps_total;
      return r;
   endfunction

   function automatic imu_pkg::req_item_type make_item(logic is_write, int x, int y, int rnd,
                                                       logic spin);
      imu_pkg::req_item_type it;
      it.req_type        = is_write;
      it.site_x          = imu_pkg::SITE_W'(x);
      it.site_y          = imu_pkg::SITE_W'(y);
      it.random_fraction = imu_pkg::RAND_W'(rnd);
      it.spin_in         = spin;
      return it;
   endfunction

   // Sites fall inside the lattice in use most of the time and anywhere in the field otherwise,
   // so that clamping is exercised without starving the neighbour interactions.
   function automatic imu_pkg::req_item_type random_item();
      int sx, sy, x, y;
      sx = used_extent(extent_x);
      sy = used_extent(extent_y);
      x  = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(sx - 1);
      y  = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(sy - 1);
      return make_item($urandom_range(99) < 25, x, y, $urandom_range(65535),
                       1'($urandom_range(1)));
   endfunction

   function automatic logic [imu_pkg::THR_W-1:0] random_threshold();
      case ($urandom_range(5))
         0:       return '0;
         1:       return 17'd65536;
         2:       return '1;
         3:       return 17'd65535;
         default: return imu_pkg::THR_W'($urandom_range(65535));
      endcase
   endfunction

   // Fills all fifteen slots, including the spare one in the last word that the core ignores.
   function automatic imu_pkg::thr_words_type random_threshold_bank();
      imu_pkg::thr_words_type bank;
      for (int w = 0; w < imu_pkg::THR_WORDS; w++) begin
         for (int k = 0; k < 3; k++) begin
            bank[w][imu_pkg::THR_W * k +: imu_pkg::THR_W] = random_threshold();
         end
      end
      return bank;
   endfunction

   // Mostly small lattices so that sites meet each other often, with the odd zero,
   // full-size and oversize setting.
   function automatic logic [imu_pkg::SIZE_W-1:0] random_extent();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 7'd1;
         2:       return 7'd2;
         3:       return 7'd64;
         4:       return imu_pkg::SIZE_W'($urandom_range(65, 127));
         5:       return imu_pkg::SIZE_W'($urandom_range(1, 64));
         default: return imu_pkg::SIZE_W'($urandom_range(3, 8));
      endcase
   endfunction

   function automatic logic [imu_pkg::SWEEP_W-1:0] random_sweep_length();
      case ($urandom_range(7))
         0:       return '0;
         1:       return 13'd1;
         2:       return imu_pkg::SWEEP_W'($urandom_range(2, 8));
         3:       return 13'd4096;
         4:       return '1;
         default: return imu_pkg::SWEEP_W'($urandom_range(5, 40));
      endcase
   endfunction

   // Offers one item from a falling edge onwards, idling first at the current rate, and keeps it
   // on the port until it transfers. The request is left high so that a following item can go
   // back to back; it is lowered only by an idle gap or by hold_requests.
   task automatic send_item(imu_pkg::req_item_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_push    <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (req_full);
      owed_results.push_back(predict_spin_update(it));
      items_sent++;
      @(negedge clock);
   endtask

   // Stops offering items and waits until every owed result has been taken, plus the
   // core's own latency so that its pipeline is known to be empty.
   task automatic hold_requests();
      req_push <= 1'b0;
      while (owed_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(imu_pkg::csr_index_type idx,
                                 logic [imu_pkg::THR_WORD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         imu_pkg::CSR_SIZE_X:       extent_x  = value[imu_pkg::SIZE_W-1:0];
         imu_pkg::CSR_SIZE_Y:       extent_y  = value[imu_pkg::SIZE_W-1:0];
         imu_pkg::CSR_SWEEP_LENGTH: sweep_len = value[imu_pkg::SWEEP_W-1:0];
         default:                   thr_bank[idx - imu_pkg::CSR_THR_WORD0] = value;
      endcase
      @(negedge clock);
   endtask

   // Writes every register once the core has gone quiet. The bits above each narrow field
   // carry noise, which the core is expected to drop.
   task automatic configure(logic [imu_pkg::SIZE_W-1:0] sx, logic [imu_pkg::SIZE_W-1:0] sy,
                            logic [imu_pkg::SWEEP_W-1:0] len, imu_pkg::thr_words_type bank);
      logic [63:0] noise;
      hold_requests();
      noise = {$urandom, $urandom};
      write_register(imu_pkg::CSR_SIZE_X, {noise[imu_pkg::THR_WORD_W-1:imu_pkg::SIZE_W], sx});
      write_register(imu_pkg::CSR_SIZE_Y, {noise[imu_pkg::THR_WORD_W-1:imu_pkg::SIZE_W], sy});
      write_register(imu_pkg::CSR_SWEEP_LENGTH,
                     {noise[imu_pkg::THR_WORD_W-1:imu_pkg::SWEEP_W], len});
      write_register(imu_pkg::CSR_THR_WORD0, bank[0]);
      write_register(imu_pkg::CSR_THR_WORD1, bank[1]);
      write_register(imu_pkg::CSR_THR_WORD2, bank[2]);
      write_register(imu_pkg::CSR_THR_WORD3, bank[3]);
      write_register(imu_pkg::CSR_THR_WORD4, bank[4]);
      csr_valid <= 1'b0;
   endtask

   // Reports a field that differs; the report count is capped so a broken core cannot flood
   // the log, but every mismatch still counts.
   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         if (errors < REPORT_LIMIT) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
         end
         errors++;
      end
   endfunction

   task automatic check_result(imu_pkg::rsp_item_type got);
      imu_pkg::rsp_item_type want;
      results_seen++;
      if (owed_results.size() == 0) begin
         if (errors < REPORT_LIMIT) begin
            $error("result transfer with no item outstanding: %h", got);
         end
         errors++;
         return;
      end
      want = owed_results.pop_front();
      compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
      compare_field("spin_after", 32'(want.spin_after), 32'(got.spin_after));
      compare_field("sweep_done", 32'(want.sweep_done), 32'(got.sweep_done));
      compare_field("sweep_accepts", 32'(want.sweep_accepts), 32'(got.sweep_accepts));
      compare_field("sweep_count", want.sweep_count, got.sweep_count);
      sweeps_seen += int'(want.sweep_done);
      flips_seen  += int'(want.accepted);
   endtask

   // The receiving side: pop is chosen afresh at every falling edge, and a result transfers
   // at a rising edge on which pop is high and the queue is not empty.
   always @(negedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         check_result(rsp_payload);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results owed", cycle_count,
                  owed_results.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // With the reset register values every threshold is zero, so nothing may flip. A write
   // followed by an attempt at the same site shows that the write landed.
   task automatic test_reset_state();
      send_item(make_item(1'b0, 0, 0, 0, 1'b0));
      send_item(make_item(1'b0, 63, 63, 65535, 1'b0));
      send_item(make_item(1'b1, 5, 5, 65535, 1'b0));
      send_item(make_item(1'b0, 5, 5, 0, 1'b1));
   endtask

   // Thresholds at both ends of the scale, the always-accept value and a random fraction on
   // either side of a threshold. The spare slot is set to all ones and must have no effect.
   task automatic test_thresholds();
      imu_pkg::thr_words_type bank;
      bank = '0;
      for (int e = 0; e < ENTRIES; e++) begin
         bank[e / 3][imu_pkg::THR_W * (e % 3) +: imu_pkg::THR_W] = imu_pkg::THR_W'(e * 5000);
      end
      bank[0][16:0]  = '0;
      bank[0][33:17] = 17'd1;
      bank[0][50:34] = '1;
      bank[4][16:0]  = 17'd65536;
      bank[4][33:17] = 17'd65535;
      bank[4][50:34] = '1;
      configure(7'd64, 7'd64, 13'd4096, bank);
      // All neighbours alike and spin up: the highest entry, at its threshold and just below it.
      send_item(make_item(1'b0, 10, 10, 65535, 1'b0));
      send_item(make_item(1'b0, 10, 10, 65534, 1'b0));
      // Now a lone down spin among up neighbours, whose entry never accepts.
      send_item(make_item(1'b0, 10, 10, 0, 1'b0));
      send_item(make_item(1'b1, 10, 11, 0, 1'b0));
      send_item(make_item(1'b0, 10, 10, 65535, 1'b1));
      // Corner sites wrap to the far edges.
      send_item(make_item(1'b0, 0, 0, 65535, 1'b1));
      send_item(make_item(1'b0, 63, 0, 0, 1'b1));
   endtask

   // A zero width acts as one and an oversize height as the built extent; then a small
   // lattice on which every coordinate beyond the edge is clamped, for writes and attempts.
   task automatic test_clamping();
      configure(7'd0, 7'd127, 13'd0, random_threshold_bank());
      send_item(make_item(1'b0, 63, 63, 100, 1'b0));
      send_item(make_item(1'b1, 63, 5, 0, 1'b0));
      send_item(make_item(1'b0, 0, 5, 30000, 1'b0));
      configure(7'd5, 7'd3, 13'd4, random_threshold_bank());
      send_item(make_item(1'b0, 63, 63, 0, 1'b0));
      send_item(make_item(1'b1, 7, 1, 0, 1'b1));
      send_item(make_item(1'b0, 4, 2, 65535, 1'b0));
      send_item(make_item(1'b0, 0, 0, 12345, 1'b0));
   endtask

   // A length cut below the running attempt count closes the sweep on the next attempt.
   task automatic test_sweep_shrink();
      imu_pkg::thr_words_type bank;
      bank = random_threshold_bank();
      configure(7'd4, 7'd4, 13'd100, bank);
      for (int i = 0; i < 4; i++) begin
         send_item(make_item(1'b0, i, i, $urandom_range(65535), 1'b0));
      end
      configure(7'd4, 7'd4, 13'd2, bank);
      send_item(make_item(1'b0, 1, 2, $urandom_range(65535), 1'b0));
      send_item(make_item(1'b1, 1, 2, 0, 1'b0));
      send_item(make_item(1'b0, 2, 1, $urandom_range(65535), 1'b0));
   endtask

   // Random items over three fresh register settings at the given idling rates.
   task automatic test_random_traffic(int send_pct, int pop_pct);
      send_idle_pct = send_pct;
      pop_idle_pct  = pop_pct;
      for (int phase = 0; phase < 3; phase++) begin
         configure(random_extent(), random_extent(), random_sweep_length(),
                   random_threshold_bank());
         for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
            send_item(random_item());
         end
      end
   endtask

   initial begin
      reset_lattice_model();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // The core clears its lattice after reset and holds req_full high meanwhile; nothing
      // is written to it until that pass is over.
      do @(posedge clock); while (req_full);
      @(negedge clock);

      test_reset_state();
      test_thresholds();
      test_clamping();
      test_sweep_shrink();
      test_random_traffic(13, 82);
      test_random_traffic(82, 13);
      test_random_traffic(0, 0);

      hold_requests();
      $display("Covered %0d items and %0d results: %0d spin flips, %0d completed sweeps,",
               items_sent, results_seen, flips_seen, sweeps_seen);
      $display("over directed edge cases and random traffic at three idling regimes.");
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/imu_pkg.sv
design/imu_fifo.sv
design/imu_front.sv
design/imu_back.sv
design/ising_metropolis_update_core.sv
sim/testbench.sv
